/* sv/lsh_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package lsh_pkg;

  localparam int FW_W       = 12;
  localparam int FH_W       = 13;
  localparam int CC_W       = 3;
  localparam int CFG_IW     = 2;
  localparam int CFG_DW     = 13;
  localparam int MAX_HEIGHT = 4096;
  localparam int ROW_W      = 13;
  localparam int OROW_W     = 12;
  localparam int RS_W       = 13;
  localparam int TS_W       = 14;
  localparam int TAPS       = 5;
  localparam int NCH        = 4;

  localparam logic [FW_W-1:0] WIDTH_RST    = 12'd640;
  localparam logic [FH_W-1:0] HEIGHT_RST   = 13'd480;
  localparam logic [CC_W-1:0] CHANNELS_RST = 3'd4;
  localparam logic [CC_W-1:0] CHANNELS_3   = 3'd3;

  typedef logic [CFG_IW-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_WIDTH    = 2'd0;
  localparam cfg_idx_t REG_HEIGHT   = 2'd1;
  localparam cfg_idx_t REG_CHANNELS = 2'd2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef logic [NCH-1:0][7:0] pix_t;
  typedef logic signed [RS_W-1:0] rsum_t;
  typedef logic signed [TS_W-1:0] tsum_t;

  typedef enum logic [1:0] {ROW_EDGE, ROW_INNER, ROW_CENTRE} row_kind_t;
  typedef enum logic [1:0] {WT_NEG, WT_TWO, WT_EIGHT} weight_t;

  typedef struct packed {
    logic            fire;
    logic            adv_b;
    logic            row_ok;
    logic [TAPS-1:0] col_ok;
  } cell_ctrl_t;

  // Kernel weight of tap m in a window row of the given kind.
  function automatic weight_t tap_weight(row_kind_t kind, int m);
    weight_t wt;
    if (m == 0 || m == TAPS - 1) begin
      wt = WT_NEG;
    end else begin
      case (kind)
        ROW_EDGE:   wt = WT_NEG;
        ROW_CENTRE: wt = (m == TAPS / 2) ? WT_EIGHT : WT_TWO;
        default:    wt = WT_TWO;
      endcase
    end
    return wt;
  endfunction

  function automatic rsum_t weigh(logic [7:0] v, weight_t wt);
    rsum_t x;
    rsum_t r;
    x = $signed({{(RS_W - 8){1'b0}}, v});
    case (wt)
      WT_NEG:   r = -x;
      WT_TWO:   r = x <<< 1;
      WT_EIGHT: r = x <<< 3;
      default:  r = '0;
    endcase
    return r;
  endfunction

  // Negative sums give zero, otherwise floor(sum / 8) limited to 255.
  function automatic logic [7:0] clamp_px(tsum_t s);
    logic [TS_W-5:0] q;
    logic [7:0]      r;
    q = s[TS_W-2:3];
    if (s[TS_W-1]) begin
      r = 8'd0;
    end else if (q > 10'd255) begin
      r = 8'hFF;
    end else begin
      r = q[7:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* sv/laplacian_sharpen_5x5_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// 5x5 Laplacian sharpening of a raster pixel stream, four 8-bit channels per beat.
// Input beats carry in_op: a pixel, or a drain step that pushes the tail of the
// frame out once every pixel of the frame has arrived. A drain before that is
// taken and ignored; a pixel after it counts as a drain.
// The result for pixel (r, c) is computed once the beat bringing pixel
// (r + 2, c + 2) has been taken, and passes through the tap, row-sum and output
// registers to the output. One beat per clock is sustained while out_stall is low.
// The window is a row of five cells, one per window row, each shifting five
// taps; four line memories of MAX_WIDTH words delay the stream by
// one line between cells. Cells form the row sums, a final stage adds and clamps.
// out_frame_end marks the last result of a frame, after which a new frame starts.
// When out_stall is held the three pipeline stages fill up and in_stall rises
// in the same cycle as the first stage can no longer move.
// Reset restores 640 x 480 with four channels and clears all positions; the
// line memories are not cleared, as rows above the frame are masked anyway.
// Width, height and channel writes restart the frame and should be made while idle.
module laplacian_sharpen_5x5_unit
  import lsh_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_op,
  input  logic [7:0]        in_pixel_c0,
  input  logic [7:0]        in_pixel_c1,
  input  logic [7:0]        in_pixel_c2,
  input  logic [7:0]        in_pixel_c3,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_c0,
  output logic [7:0]        out_c1,
  output logic [7:0]        out_c2,
  output logic [7:0]        out_c3,
  output logic              out_frame_end,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int LW = WW + 2;
  localparam int XW = ((WW > FW_W) ? WW : FW_W) + 2;
  localparam int HW = FH_W + 1;

  logic [FW_W-1:0] frame_width_r;
  logic [FH_W-1:0] frame_height_r;
  logic [CC_W-1:0] channel_count_r;

  logic [XW-1:0]     fw_x;
  logic [XW-1:0]     eff_w_x;
  logic [WW-1:0]     eff_w;
  logic [WW-1:0]     w_m1;
  logic [CW-1:0]     last_col;
  logic [FH_W-1:0]   eff_h;
  logic [FH_W-1:0]   h_m1;
  logic [OROW_W-1:0] last_row;
  logic [LW-1:0]     lag;
  logic              four;

  logic [CW-1:0]     in_col_r, in_col_nxt;
  logic [ROW_W-1:0]  in_row_r, in_row_nxt;
  logic [CW-1:0]     out_col_r, out_col_nxt;
  logic [OROW_W-1:0] out_row_r, out_row_nxt;
  logic [LW-1:0]     lag_r, lag_nxt;

  logic adv_a, adv_b, adv_c;
  logic accept, fire, in_frame, emit, last, restart, cfg_wr, cfg_hit;
  pix_t word;

  logic            va_r, vb_r, out_valid_r;
  logic            last_a_r, last_b_r, frame_end_r;
  logic [TAPS-1:0] row_ok_r, row_ok_nxt;
  logic [TAPS-1:0] col_ok_r, col_ok_nxt;
  pix_t            out_px_r;

  pix_t       stream [TAPS];
  rsum_t      rs     [TAPS][NCH];
  tsum_t      tot    [NCH];
  cell_ctrl_t cctrl  [TAPS];

  logic [HW-1:0] r_x, h_x;
  logic [XW-1:0] c_x, w_x;

  // Effective frame size, with out-of-range register values clamped.
  always_comb begin
    fw_x = XW'(frame_width_r);
    if (fw_x == '0) begin
      eff_w_x = XW'(1);
    end else if (fw_x > XW'(MAX_WIDTH)) begin
      eff_w_x = XW'(MAX_WIDTH);
    end else begin
      eff_w_x = fw_x;
    end
    if (frame_height_r == '0) begin
      eff_h = FH_W'(1);
    end else if (frame_height_r > FH_W'(MAX_HEIGHT)) begin
      eff_h = FH_W'(MAX_HEIGHT);
    end else begin
      eff_h = frame_height_r;
    end
  end

  assign eff_w    = eff_w_x[WW-1:0];
  assign w_m1     = eff_w - 1'b1;
  assign last_col = w_m1[CW-1:0];
  assign h_m1     = eff_h - 1'b1;
  assign last_row = h_m1[OROW_W-1:0];
  assign lag      = LW'({eff_w, 1'b0}) + LW'(2);
  assign four     = channel_count_r > CHANNELS_3;

  // Stage handshake: a stage moves when it is empty or its successor moves.
  assign adv_c    = !out_valid_r || !out_stall;
  assign adv_b    = !vb_r || adv_c;
  assign adv_a    = !va_r || adv_b;
  assign in_stall = !adv_a;
  assign accept   = in_valid && adv_a;

  assign in_frame = in_row_r < eff_h;
  assign fire     = accept && (!in_frame || in_op == OP_PIXEL);
  assign emit     = lag_r == lag;
  assign last     = emit && out_row_r == last_row && out_col_r == last_col;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_wr && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT ||
                                cfg_index == REG_CHANNELS);
  assign restart   = cfg_hit || (fire && last);

  always_comb begin
    word = '0;
    if (in_frame) begin
      word[0] = in_pixel_c0;
      word[1] = in_pixel_c1;
      word[2] = in_pixel_c2;
      word[3] = four ? in_pixel_c3 : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= WIDTH_RST;
      frame_height_r  <= HEIGHT_RST;
      channel_count_r <= CHANNELS_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_WIDTH:    frame_width_r   <= cfg_data[FW_W-1:0];
        REG_HEIGHT:   frame_height_r  <= cfg_data[FH_W-1:0];
        REG_CHANNELS: channel_count_r <= cfg_data[CC_W-1:0];
        default:      frame_width_r   <= frame_width_r;
      endcase
    end
  end

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    lag_nxt     = lag_r;
    if (restart) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      lag_nxt     = '0;
    end else if (fire) begin
      if (in_col_r == last_col) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + 1'b1;
      end else begin
        in_col_nxt = in_col_r + 1'b1;
      end
      if (emit) begin
        if (out_col_r == last_col) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + 1'b1;
        end else begin
          out_col_nxt = out_col_r + 1'b1;
        end
      end else begin
        lag_nxt = lag_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      lag_r     <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      lag_r     <= lag_nxt;
    end
  end

  // Which window rows and columns lie inside the frame for the result being
  // formed. Cell k holds the row k lines back, tap m the pixel m places back.
  assign r_x = HW'(out_row_r);
  assign h_x = HW'(eff_h);
  assign c_x = XW'(out_col_r);
  assign w_x = XW'(eff_w);

  always_comb begin
    row_ok_nxt[0] = r_x + HW'(3) <= h_x;
    row_ok_nxt[1] = r_x + HW'(2) <= h_x;
    row_ok_nxt[2] = 1'b1;
    row_ok_nxt[3] = out_row_r != '0;
    row_ok_nxt[4] = r_x >= HW'(2);
    col_ok_nxt[0] = c_x + XW'(3) <= w_x;
    col_ok_nxt[1] = c_x + XW'(2) <= w_x;
    col_ok_nxt[2] = 1'b1;
    col_ok_nxt[3] = out_col_r != '0;
    col_ok_nxt[4] = c_x >= XW'(2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv_a) begin
        va_r <= fire && emit;
      end
      if (adv_b) begin
        vb_r <= va_r;
      end
      if (adv_c) begin
        out_valid_r <= vb_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      last_a_r <= last;
      row_ok_r <= row_ok_nxt;
      col_ok_r <= col_ok_nxt;
    end
    if (adv_b) begin
      last_b_r <= last_a_r;
    end
    if (adv_c) begin
      frame_end_r <= last_b_r;
      for (int ch = 0; ch < NCH; ch++) begin
        out_px_r[ch] <= clamp_px(tot[ch]);
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      tot[ch] = '0;
      for (int k = 0; k < TAPS; k++) begin
        tot[ch] = tot[ch] + TS_W'(rs[k][ch]);
      end
    end
  end

  assign stream[0] = word;

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    localparam row_kind_t KIND = (k == 0 || k == TAPS - 1) ? ROW_EDGE :
                                 (k == TAPS / 2) ? ROW_CENTRE : ROW_INNER;

    assign cctrl[k].fire   = fire;
    assign cctrl[k].adv_b  = adv_b;
    assign cctrl[k].row_ok = row_ok_r[k];
    assign cctrl[k].col_ok = col_ok_r;

    lsh_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (cctrl[k]),
      .kind    (KIND),
      .din     (stream[k]),
      .row_sum (rs[k])
    );

    if (k < TAPS - 1) begin : g_line
      lsh_line #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
      ) u_line (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .restart  (restart),
        .last_idx (last_col),
        .din      (stream[k]),
        .dout     (stream[k+1])
      );
    end
  end

  assign out_valid     = out_valid_r;
  assign out_c0        = out_px_r[0];
  assign out_c1        = out_px_r[1];
  assign out_c2        = out_px_r[2];
  assign out_c3        = out_px_r[3];
  assign out_frame_end = frame_end_r;

endmodule
`default_nettype wire

/* sv/lsh_line.sv */
`timescale 1ns / 1ps
`default_nettype none
module lsh_line
  import lsh_pkg::*;
#(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  logic          restart,
  input  logic [AW-1:0] last_idx,
  input  pix_t          din,
  output pix_t          dout
);

  logic [AW-1:0] ptr_r;
  logic [AW-1:0] ptr_nxt;
  pix_t          mem [DEPTH];
  pix_t          rd_r;

  always_comb begin
    ptr_nxt = ptr_r;
    if (restart) begin
      ptr_nxt = '0;
    end else if (fire) begin
      ptr_nxt = (ptr_r == last_idx) ? '0 : ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else begin
      ptr_r <= ptr_nxt;
    end
  end

  // The read register always shows the entry under the pointer, which was
  // written one line ago. With a one-pixel line that is the word just written.
  always_ff @(posedge clk) begin
    if (fire) begin
      mem[ptr_r] <= din;
    end
    if (fire && ptr_nxt == ptr_r) begin
      rd_r <= din;
    end else begin
      rd_r <= mem[ptr_nxt];
    end
  end

  assign dout = rd_r;

endmodule
`default_nettype wire

/* sv/lsh_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
module lsh_cell
  import lsh_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  row_kind_t  kind,
  input  pix_t       din,
  output rsum_t      row_sum [NCH]
);

  pix_t  taps_r  [TAPS];
  rsum_t sum_nxt [NCH];
  rsum_t sum_r   [NCH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int m = 0; m < TAPS; m++) begin
        taps_r[m] <= '0;
      end
    end else if (ctrl.fire) begin
      taps_r[0] <= din;
      for (int m = 1; m < TAPS; m++) begin
        taps_r[m] <= taps_r[m-1];
      end
    end
  end

  // Taps that fall outside the frame contribute nothing.
  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      sum_nxt[ch] = '0;
      for (int m = 0; m < TAPS; m++) begin
        if (ctrl.row_ok && ctrl.col_ok[m]) begin
          sum_nxt[ch] = sum_nxt[ch] + weigh(taps_r[m][ch], tap_weight(kind, m));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv_b) begin
      sum_r <= sum_nxt;
    end
  end

  assign row_sum = sum_r;

endmodule
`default_nettype wire

/* sv/lsh_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module lsh_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_c0,
  input logic [7:0] out_c1,
  input logic [7:0] out_c2,
  input logic [7:0] out_c3,
  input logic       out_frame_end
);

  // A stalled result beat stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid &&
      $stable({out_c0, out_c1, out_c2, out_c3, out_frame_end}))
    else $error("stalled result beat changed or vanished");

  // Reset empties the pipeline, so the input side is open straight after it.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // The input only stalls when the output register is full and held back.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || !out_stall) |-> !in_stall)
    else $error("input stalled while the output side can move");

endmodule

bind laplacian_sharpen_5x5_unit lsh_checker u_lsh_checker (.*);
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
  import lsh_pkg::*;

  localparam int MAX_W       = 2048;
  localparam int HIST        = 4 * MAX_W + 8;
  localparam int SETTLE      = 8;
  localparam int QUIET_LIMIT = 20000;
  localparam int BEATS_EACH  = 667;

  localparam cfg_idx_t REG_SPARE = 2'd3;

  typedef struct packed {
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic [7:0] c3;
    logic       frame_end;
  } sharp_px_t;

  typedef struct packed {
    logic      pinned;
    sharp_px_t want;
  } pin_t;

  typedef enum logic {STEP_BEAT, STEP_CFG} step_t;

  typedef struct packed {
    step_t             kind;
    logic              op;
    pix_t              px;
    cfg_idx_t          idx;
    logic [CFG_DW-1:0] data;
    pin_t              pin;
  } plan_row_t;

  localparam pin_t NO_PIN = '0;
  localparam int PLAN_ROWS = 25;

  // Drain before any pixel, a frame abandoned by a write, a 1x1 frame whose result is the
  // pixel itself, and a 3x1 three-channel frame hitting both clamps with a surplus pixel.
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{STEP_BEAT, OP_DRAIN, 32'h0000_0000, REG_WIDTH, 13'd0, NO_PIN},
    '{STEP_BEAT, OP_PIXEL, 32'h0403_0201, REG_WIDTH, 13'd0, NO_PIN},
    '{STEP_BEAT, OP_PIXEL, 32'h8080_8080, REG_WIDTH, 13'd0, NO_PIN},
    '{STEP_CFG, OP_PIXEL, 32'h0, REG_WIDTH, 13'd1, NO_PIN},
    '{STEP_CFG, OP_PIXEL, 32'h0, REG_HEIGHT, 13'd1, NO_PIN},
    '{STEP_CFG, OP_PIXEL, 32'h0, REG_SPARE, 13'h1fff, NO_PIN},
    '{STEP_BEAT, OP_DRAIN, 32'h0000_0000, REG_WIDTH, 13'd0, NO_PIN},
    '{STEP_BEAT, OP_PIXEL, 32'h5aa5_00ff, REG_WIDTH, 13'd0, NO_PIN},
    '{STEP_BEAT, OP_DRAIN, 32'h0000_0000, REG_WIDTH, 13'd0, NO_PIN},
    '{STEP_BEAT, OP_DRAIN, 32'h0000_0000, REG_WIDTH, 13'd0, NO_PIN},
    '{STEP_BEAT, OP_DRAIN, 32'h0000_0000, REG_WIDTH, 13'd0, NO_PIN},
    '{STEP_BEAT, OP_DRAIN, 32'h0, REG_WIDTH, 13'd0,
      '{1'b1, '{8'hff, 8'h00, 8'ha5, 8'h5a, 1'b1}}},
    '{STEP_CFG, OP_PIXEL, 32'h0, REG_WIDTH, 13'd3, NO_PIN},
    '{STEP_CFG, OP_PIXEL, 32'h0, REG_CHANNELS, 13'd3, NO_PIN},
    '{STEP_BEAT, OP_PIXEL, 32'hff00_ff00, REG_WIDTH, 13'd0, NO_PIN},
    '{STEP_BEAT, OP_PIXEL, 32'hff00_ff00, REG_WIDTH, 13'd0, NO_PIN},
    '{STEP_BEAT, OP_PIXEL, 32'hff00_ffff, REG_WIDTH, 13'd0, NO_PIN},
    '{STEP_BEAT, OP_PIXEL, 32'h7856_3412, REG_WIDTH, 13'd0, NO_PIN},
    '{STEP_BEAT, OP_DRAIN, 32'h0000_0000, REG_WIDTH, 13'd0, NO_PIN},
    '{STEP_BEAT, OP_DRAIN, 32'h0000_0000, REG_WIDTH, 13'd0, NO_PIN},
    '{STEP_BEAT, OP_DRAIN, 32'h0000_0000, REG_WIDTH, 13'd0, NO_PIN},
    '{STEP_BEAT, OP_DRAIN, 32'h0000_0000, REG_WIDTH, 13'd0, NO_PIN},
    '{STEP_BEAT, OP_DRAIN, 32'h0, REG_WIDTH, 13'd0,
      '{1'b1, '{8'h00, 8'hff, 8'h00, 8'h00, 1'b0}}},
    '{STEP_BEAT, OP_DRAIN, 32'h0, REG_WIDTH, 13'd0,
      '{1'b1, '{8'h3f, 8'hff, 8'h00, 8'h00, 1'b0}}},
    '{STEP_BEAT, OP_DRAIN, 32'h0, REG_WIDTH, 13'd0,
      '{1'b1, '{8'hff, 8'hff, 8'h00, 8'h00, 1'b1}}}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_op = OP_PIXEL;
  logic [7:0]        in_pixel_c0 = 8'd0;
  logic [7:0]        in_pixel_c1 = 8'd0;
  logic [7:0]        in_pixel_c2 = 8'd0;
  logic [7:0]        in_pixel_c3 = 8'd0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        out_c0;
  logic [7:0]        out_c1;
  logic [7:0]        out_c2;
  logic [7:0]        out_c3;
  logic              out_frame_end;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  cfg_idx_t          cfg_index = REG_WIDTH;
  logic [CFG_DW-1:0] cfg_data = '0;

  laplacian_sharpen_5x5_unit #(.MAX_WIDTH(MAX_W)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_pixel_c0(in_pixel_c0), .in_pixel_c1(in_pixel_c1),
    .in_pixel_c2(in_pixel_c2), .in_pixel_c3(in_pixel_c3),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_c0(out_c0), .out_c1(out_c1), .out_c2(out_c2), .out_c3(out_c3),
    .out_frame_end(out_frame_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Sharpening predictor: its own pixel history, raster positions and registers.
  logic [31:0]     pix_history [HIST];
  int              hist_wr = 0;
  int              arr_col = 0;
  int              arr_row = 0;
  int              res_col = 0;
  int              res_row = 0;
  logic [FW_W-1:0] cfg_width = WIDTH_RST;
  logic [FH_W-1:0] cfg_height = HEIGHT_RST;
  logic [CC_W-1:0] cfg_chans = CHANNELS_RST;

  sharp_px_t pending_px [$];
  pin_t      pin_q [$];
  int        faults = 0;
  int        quiet_cycles = 0;
  int        tx_idle = 0;
  int        rx_idle = 0;

  function automatic int eff_dim(int v, int hi);
    return (v < 1) ? 1 : ((v > hi) ? hi : v);
  endfunction

  function automatic void restart_raster();
    arr_col = 0;
    arr_row = 0;
    res_col = 0;
    res_row = 0;
  endfunction

  function automatic logic [7:0] sharpen_ch(int newest, int w, int h, int ch);
    int acc;
    int tap;
    int idx;
    acc = 0;
    for (int i = -2; i <= 2; i++) begin
      for (int j = -2; j <= 2; j++) begin
        if (res_row + i >= 0 && res_row + i < h && res_col + j >= 0 && res_col + j < w) begin
          tap = (i == -2 || i == 2 || j == -2 || j == 2) ? -1 : ((i == 0 && j == 0) ? 8 : 2);
          idx = (newest + HIST - ((2 - i) * w + (2 - j))) % HIST;
          acc += tap * int'(pix_history[idx][8 * ch +: 8]);
        end
      end
    end
    if (acc < 0) return 8'h00;
    acc = acc >>> 3;
    return (acc > 255) ? 8'hff : 8'(acc);
  endfunction

  // Returns 1 when the beat releases a sharpened pixel.
  function automatic bit sharpen_beat(input logic op, input pix_t px, output sharp_px_t res);
    int          w;
    int          h;
    int          total;
    int          count;
    int          newest;
    logic [31:0] word;
    bit          four;
    w = eff_dim(cfg_width, MAX_W);
    h = eff_dim(cfg_height, MAX_HEIGHT);
    total = w * h;
    count = arr_row * w + arr_col;
    four = cfg_chans > CHANNELS_3;
    res = '0;
    if (count < total) begin
      // A drain before the last pixel of the frame changes nothing.
      if (op == OP_DRAIN) return 1'b0;
      word = {four ? px[3] : 8'h00, px[2], px[1], px[0]};
    end else begin
      word = '0;
    end
    pix_history[hist_wr] = word;
    newest = hist_wr;
    hist_wr = (hist_wr + 1) % HIST;
    arr_col++;
    if (arr_col >= w) begin
      arr_col = 0;
      arr_row++;
    end
    if (count < 2 * w + 2) return 1'b0;
    res.c0 = sharpen_ch(newest, w, h, 0);
    res.c1 = sharpen_ch(newest, w, h, 1);
    res.c2 = sharpen_ch(newest, w, h, 2);
    res.c3 = four ? sharpen_ch(newest, w, h, 3) : 8'h00;
    res.frame_end = (res_row == h - 1) && (res_col == w - 1);
    if (res.frame_end) begin
      restart_raster();
    end else begin
      res_col++;
      if (res_col >= w) begin
        res_col = 0;
        res_row++;
      end
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin : monitor
    sharp_px_t predicted;
    sharp_px_t got;
    sharp_px_t want;
    pin_t      pin;
    bit        moved;
    if (rst_n) begin
      moved = 1'b0;
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        case (cfg_index)
          REG_WIDTH: begin
            cfg_width = cfg_data[FW_W-1:0];
            restart_raster();
          end
          REG_HEIGHT: begin
            cfg_height = cfg_data[FH_W-1:0];
            restart_raster();
          end
          REG_CHANNELS: begin
            cfg_chans = cfg_data[CC_W-1:0];
            restart_raster();
          end
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        pin = (pin_q.size() != 0) ? pin_q.pop_front() : NO_PIN;
        if (sharpen_beat(in_op, {in_pixel_c3, in_pixel_c2, in_pixel_c1, in_pixel_c0},
                         predicted) && !pin.pinned) begin
          pending_px.push_back(predicted);
        end
        if (pin.pinned) pending_px.push_back(pin.want);
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        got = '{out_c0, out_c1, out_c2, out_c3, out_frame_end};
        if (pending_px.size() == 0) begin
          $error("unexpected result beat: c0 %0d c1 %0d c2 %0d c3 %0d frame_end %0d",
                 got.c0, got.c1, got.c2, got.c3, got.frame_end);
          faults++;
        end else begin
          want = pending_px.pop_front();
          if (got.c0 !== want.c0) begin
            $error("out_c0: expected %0d, actual %0d", want.c0, got.c0);
            faults++;
          end
          if (got.c1 !== want.c1) begin
            $error("out_c1: expected %0d, actual %0d", want.c1, got.c1);
            faults++;
          end
          if (got.c2 !== want.c2) begin
            $error("out_c2: expected %0d, actual %0d", want.c2, got.c2);
            faults++;
          end
          if (got.c3 !== want.c3) begin
            $error("out_c3: expected %0d, actual %0d", want.c3, got.c3);
            faults++;
          end
          if (got.frame_end !== want.frame_end) begin
            $error("out_frame_end: expected %0d, actual %0d", want.frame_end, got.frame_end);
            faults++;
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rx_idle);
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("laplacian_sharpen_5x5_unit regression: fail");
    $finish;
  end

  // The extra cycles cover a drain beat still travelling through the pipeline.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_px.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_DW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_beat(input logic op, input pix_t px, input pin_t pin);
    while ($urandom_range(0, 99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_pixel_c0 <= px[0];
    in_pixel_c1 <= px[1];
    in_pixel_c2 <= px[2];
    in_pixel_c3 <= px[3];
    pin_q.push_back(pin);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic random_config();
    int v;
    if ($urandom_range(0, 5) == 0) cfg_write(REG_SPARE, 13'($urandom));
    if ($urandom_range(0, 3) != 0 || $urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 9))
        0:       v = 0;
        1:       v = $urandom_range(9, 40);
        default: v = $urandom_range(1, 8);
      endcase
      cfg_write(REG_WIDTH, {1'($urandom), 12'(v)});
    end
    case ($urandom_range(0, 9))
      0:       v = 0;
      1:       v = $urandom_range(7, 12);
      default: v = $urandom_range(1, 6);
    endcase
    cfg_write(REG_HEIGHT, 13'(v));
    if ($urandom_range(0, 2) != 0) cfg_write(REG_CHANNELS, 13'($urandom));
  endtask

  // Streams one frame: pixels with a few early drains mixed in, then a random mix of
  // surplus pixels and drains until the last result leaves. An abandoned frame stops early.
  task automatic run_frame(input bit abandon, output int advanced);
    int   w;
    int   total;
    int   stop;
    bit   paused;
    logic op;
    pix_t px;
    w = eff_dim(cfg_width, MAX_W);
    total = w * eff_dim(cfg_height, MAX_HEIGHT);
    stop = total + 2 * w + 2;
    if (abandon) stop = $urandom_range(1, stop - 1);
    advanced = 0;
    paused = 1'b0;
    while (advanced < stop) begin
      if (!paused && advanced == stop / 2 && $urandom_range(0, 3) == 0) begin
        paused = 1'b1;
        wait_quiet();
      end
      for (int k = 0; k < NCH; k++) begin
        px[k] = ($urandom_range(0, 4) == 0) ? {8{$urandom_range(0, 1) == 1}} : 8'($urandom);
      end
      if (advanced < total) begin
        op = ($urandom_range(0, 19) == 0) ? OP_DRAIN : OP_PIXEL;
      end else begin
        op = ($urandom_range(0, 1) == 1) ? OP_DRAIN : OP_PIXEL;
      end
      if (advanced >= total || op == OP_PIXEL) advanced++;
      send_beat(op, px, NO_PIN);
    end
  endtask

  initial begin : stimulus
    int spent;
    int got_beats;
    bit redo;
    bit abandon;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tx_idle = 32;
    rx_idle = 80;
    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (PLAN[r].kind == STEP_CFG) begin
        wait_quiet();
        cfg_write(PLAN[r].idx, PLAN[r].data);
      end else begin
        send_beat(PLAN[r].op, PLAN[r].px, PLAN[r].pin);
      end
    end
    for (int regime = 0; regime < 3; regime++) begin
      tx_idle = (regime == 0) ? 32 : ((regime == 1) ? 80 : 0);
      rx_idle = (regime == 0) ? 80 : ((regime == 1) ? 32 : 0);
      if (regime == 2) begin
        // Widest and tallest frames, with register values past the clamps.
        wait_quiet();
        cfg_write(REG_WIDTH, 13'h1fff);
        cfg_write(REG_HEIGHT, 13'd1);
        cfg_write(REG_CHANNELS, 13'd7);
        run_frame(1'b0, got_beats);
        wait_quiet();
        cfg_write(REG_WIDTH, 13'd1);
        cfg_write(REG_HEIGHT, 13'h1fff);
        cfg_write(REG_CHANNELS, 13'd0);
        run_frame(1'b0, got_beats);
      end
      spent = 0;
      redo = 1'b1;
      while (spent < BEATS_EACH) begin
        if (redo || $urandom_range(0, 2) != 0) begin
          wait_quiet();
          random_config();
        end
        abandon = ($urandom_range(0, 7) == 0);
        run_frame(abandon, got_beats);
        spent += got_beats;
        redo = abandon;
      end
    end
    wait_quiet();
    if (faults == 0) begin
      $display("laplacian_sharpen_5x5_unit regression: pass");
    end else begin
      $display("laplacian_sharpen_5x5_unit regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/lsh_pkg.sv
sv/lsh_line.sv
sv/lsh_cell.sv
sv/laplacian_sharpen_5x5_unit.sv
sv/lsh_checker.sv
tb/tb.sv
